@@ rtl/ssnf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ssnf_pkg;

   localparam int DIGITS_PER_HALF = 4;
   localparam int MAX_DIGITS      = 5;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [7:0]  BLANK_CODE = 8'h0F;
   localparam logic [3:0]  HALF_LOW_TOP  = 4'(DIGITS_PER_HALF);
   localparam logic [3:0]  HALF_HIGH_TOP = 4'(2 * DIGITS_PER_HALF);

   // x / 10 == (x * 52429) >> 19 for every 16-bit x
   localparam logic [31:0] DIV10_MAGIC = 32'd52429;
   localparam int          DIV10_SHIFT = 19;

   typedef logic [3:0] bcd_type;

   typedef struct packed {
      bcd_type [MAX_DIGITS-1:0] digits;
      logic [2:0]               count;
      logic [1:0]               point;
      logic                     half;
      logic [1:0]               chip;
   } desc_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_BLANK,
      BACK_DIGIT
   } back_state_type;

endpackage
`default_nettype wire

@@ rtl/ssnf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ssnf_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [15:0]       req_value,
   input  wire logic              req_half,
   input  wire logic [1:0]        req_point_position,
   input  wire logic [1:0]        req_chip_select,
   output ssnf_pkg::desc_type     desc,
   output logic                   push,
   input  wire logic              full
);
   import ssnf_pkg::*;

   front_state_type state_ff, state_in;

   logic [15:0]              rem_ff, rem_in;
   logic [2:0]               step_ff, step_in;
   bcd_type [MAX_DIGITS-1:0] digits_ff, digits_in;
   logic [2:0]               ndig_ff, ndig_in;
   logic [1:0]               point_ff, point_in;
   logic                     half_ff, half_in;
   logic [1:0]               chip_ff, chip_in;
   logic                     zero_ff, zero_in;

   logic [31:0] prod;
   logic [12:0] quot;
   logic [15:0] quot_x10;
   logic [15:0] diff;
   bcd_type     digit;
   logic        accept;
   logic [2:0]  pad_count;

   // one decimal digit per cycle by reciprocal multiply
   assign prod     = 32'(rem_ff) * DIV10_MAGIC;
   assign quot     = prod[DIV10_SHIFT+12:DIV10_SHIFT];
   assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
   assign diff     = rem_ff - quot_x10;
   assign digit    = diff[3:0];

   assign accept = start && (state_ff == FRONT_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE: begin
            if (start) state_in = FRONT_DIVIDE;
         end
         FRONT_DIVIDE: begin
            if (quot == 13'd0) state_in = FRONT_PUSH;
         end
         FRONT_PUSH: begin
            if (!full) state_in = FRONT_IDLE;
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy = 1'b1;
      push = 1'b0;
      case (state_ff)
         FRONT_IDLE:   busy = 1'b0;
         FRONT_DIVIDE: busy = 1'b1;
         FRONT_PUSH:   push = !full;
         default:      busy = 1'b1;
      endcase
   end

   // datapath
   always_comb begin
      rem_in    = rem_ff;
      step_in   = step_ff;
      digits_in = digits_ff;
      ndig_in   = ndig_ff;
      point_in  = point_ff;
      half_in   = half_ff;
      chip_in   = chip_ff;
      zero_in   = zero_ff;
      if (accept) begin
         rem_in    = req_value;
         step_in   = 3'd0;
         digits_in = '0;
         point_in  = req_point_position;
         half_in   = req_half;
         chip_in   = req_chip_select;
         zero_in   = (req_value == 16'd0);
      end else if (state_ff == FRONT_DIVIDE) begin
         rem_in  = {3'b000, quot};
         step_in = step_ff + 3'd1;
         ndig_in = step_ff + 3'd1;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            if (step_ff == 3'(i)) digits_in[i] = digit;
         end
      end
   end

   // leading zeros so that the point digit is written
   assign pad_count = {1'b0, point_ff} + 3'd1;

   always_comb begin
      desc.digits = digits_ff;
      desc.half   = half_ff;
      desc.chip   = chip_ff;
      desc.point  = zero_ff ? 2'd0 : point_ff;
      desc.count  = ndig_ff;
      if (!zero_ff && (point_ff != 2'd0) && (pad_count > ndig_ff)) desc.count = pad_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      digits_ff <= digits_in;
      ndig_ff   <= ndig_in;
      point_ff  <= point_in;
      half_ff   <= half_in;
      chip_ff   <= chip_in;
      zero_ff   <= zero_in;
   end

endmodule
`default_nettype wire

@@ rtl/ssnf_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ssnf_queue #(
   parameter int DEPTH = ssnf_pkg::QUEUE_DEPTH
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  ssnf_pkg::desc_type  push_data,
   input  wire logic           pop,
   output ssnf_pkg::desc_type  pop_data,
   output logic                full,
   output logic                empty
);
   import ssnf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) fill_in = fill_ff + CNT_W'(1);
      else if (do_pop && !do_push) fill_in = fill_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

@@ rtl/ssnf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ssnf_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  ssnf_pkg::desc_type  pop_data,
   input  wire logic           empty,
   output logic                pop,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_target_chip,
   output logic [3:0]          rsp_register_address,
   output logic [7:0]          rsp_write_data,
   output logic                rsp_last_write
);
   import ssnf_pkg::*;

   back_state_type state_ff, state_in;
   desc_type       desc_ff, desc_in;
   logic [2:0]     cnt_ff, cnt_in;

   logic [3:0] top;
   logic       last;
   logic       point_hit;

   assign top       = desc_ff.half ? HALF_HIGH_TOP : HALF_LOW_TOP;
   assign last      = (state_ff == BACK_DIGIT) && (cnt_ff == desc_ff.count - 3'd1);
   assign point_hit = (desc_ff.point != 2'd0) && (cnt_ff == {1'b0, desc_ff.point});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!empty) state_in = BACK_BLANK;
         end
         BACK_BLANK: begin
            if (cnt_ff == 3'(DIGITS_PER_HALF - 1)) state_in = BACK_DIGIT;
         end
         BACK_DIGIT: begin
            if (last) state_in = empty ? BACK_IDLE : BACK_BLANK;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop                  = 1'b0;
      rsp_strobe           = 1'b0;
      rsp_target_chip      = desc_ff.chip;
      rsp_register_address = top - {1'b0, cnt_ff};
      rsp_write_data       = BLANK_CODE;
      rsp_last_write       = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            pop = !empty;
         end
         BACK_BLANK: begin
            rsp_strobe = 1'b1;
         end
         BACK_DIGIT: begin
            rsp_strobe     = 1'b1;
            rsp_write_data = {point_hit, 3'b000, desc_ff.digits[cnt_ff]};
            rsp_last_write = last;
            pop            = last && !empty;
         end
         default: pop = 1'b0;
      endcase
   end

   always_comb begin
      desc_in = desc_ff;
      cnt_in  = cnt_ff + 3'd1;
      if (pop) begin
         desc_in = pop_data;
         cnt_in  = 3'd0;
      end else if (state_ff == BACK_BLANK && cnt_ff == 3'(DIGITS_PER_HALF - 1)) begin
         cnt_in = 3'd0;
      end else if (state_ff == BACK_IDLE) begin
         cnt_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      desc_ff <= desc_in;
   end

endmodule
`default_nettype wire

@@ rtl/seven_segment_number_formatter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// formats a 16-bit unsigned number into digit register writes for a code-B display driver
// input channel: an item is taken at a clock edge with start high and busy low
//   (req_value, req_half, req_point_position, req_chip_select)
// result channel: one register write per cycle while rsp_strobe is high;
//   rsp_last_write marks the final write of an item; the receiver cannot stall
// each item gives four blank writes for its half, then its decimal digits
//   least significant first, padded with zeros up to the point digit
// front: converts the value one decimal digit per cycle with a reciprocal
//   multiply (1..5 significant digits) and holds busy until its descriptor is pushed
// queue: a short descriptor queue lets the front take the next item while
//   the back is still writing; the front holds busy when the queue is full
// back: streams 4 + n writes (n = 1..5) back to back, at most 9 per item
// with the back idle, the first write follows the conversion, the queue push and the pop
// sustained throughput is set by the back's write stream, not by the conversion
// reset empties the queue and returns both front and back to idle
module seven_segment_number_formatter #(
   parameter int QUEUE_DEPTH = ssnf_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_value,
   input  wire logic        req_half,
   input  wire logic [1:0]  req_point_position,
   input  wire logic [1:0]  req_chip_select,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_target_chip,
   output logic [3:0]       rsp_register_address,
   output logic [7:0]       rsp_write_data,
   output logic             rsp_last_write
);
   import ssnf_pkg::*;

   // descriptor handed from front to back
   desc_type front_desc;
   desc_type queue_head;
   logic     push;
   logic     pop;
   logic     full;
   logic     empty;

   // digit conversion
   ssnf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_value          (req_value),
      .req_half           (req_half),
      .req_point_position (req_point_position),
      .req_chip_select    (req_chip_select),
      .desc               (front_desc),
      .push               (push),
      .full               (full)
   );

   // decouples conversion from the write stream
   ssnf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_desc),
      .pop       (pop),
      .pop_data  (queue_head),
      .full      (full),
      .empty     (empty)
   );

   // blank and digit write sequencer
   ssnf_back u_back (
      .clock                (clock),
      .reset                (reset),
      .pop_data             (queue_head),
      .empty                (empty),
      .pop                  (pop),
      .rsp_strobe           (rsp_strobe),
      .rsp_target_chip      (rsp_target_chip),
      .rsp_register_address (rsp_register_address),
      .rsp_write_data       (rsp_write_data),
      .rsp_last_write       (rsp_last_write)
   );

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import ssnf_pkg::*;

   localparam logic [7:0] POINT_BIT = 8'h80;
   // no item or write for this long means the block has hung
   localparam int QUIET_LIMIT = 1000;
   localparam int MAX_GAP = 20;
   localparam int ITEMS_PER_PHASE = 80;
   // settle time after the last write, covers a full divide plus write stream
   localparam int SETTLE_CYCLES = 30;

   // one display register write as the block should emit it
   typedef struct packed {
      logic [1:0] chip;
      logic [3:0] addr;
      logic [7:0] data;
      logic       last;
   } digit_write_type;

   // directed stimulus row; n_digits of 0 leaves the digits to the predictor
   typedef struct {
      logic [15:0]     value;
      logic            half;
      logic [1:0]      point;
      logic [1:0]      chip;
      int              n_digits;
      logic [0:4][7:0] digits;
   } number_row_type;

   localparam int N_ROWS = 19;

   // digit writes are listed in emit order: least significant first
   number_row_type directed_rows [N_ROWS] = '{
      // zero writes one plain 0 whatever the point says
      '{16'd0,     1'b0, 2'd0, 2'd0, 1, {8'h00, 32'h0}},
      '{16'd0,     1'b1, 2'd3, 2'd3, 1, {8'h00, 32'h0}},
      // largest value: fifth digit spills to address 0 or into the low half
      '{16'd65535, 1'b0, 2'd0, 2'd1, 5, {8'h05, 8'h03, 8'h05, 8'h05, 8'h06}},
      '{16'd65535, 1'b1, 2'd0, 2'd2, 5, {8'h05, 8'h03, 8'h05, 8'h05, 8'h06}},
      '{16'd65535, 1'b1, 2'd3, 2'd3, 5, {8'h05, 8'h03, 8'h05, 8'h85, 8'h06}},
      // point past the digits pads with leading zeros
      '{16'd1,     1'b0, 2'd3, 2'd0, 4, {8'h01, 8'h00, 8'h00, 8'h80, 8'h00}},
      '{16'd1,     1'b0, 2'd1, 2'd1, 2, {8'h01, 8'h80, 24'h0}},
      '{16'd1,     1'b1, 2'd2, 2'd2, 3, {8'h01, 8'h00, 8'h80, 16'h0}},
      '{16'd9,     1'b0, 2'd0, 2'd3, 1, {8'h09, 32'h0}},
      '{16'd10,    1'b1, 2'd1, 2'd0, 2, {8'h00, 8'h81, 24'h0}},
      '{16'd10000, 1'b0, 2'd3, 2'd1, 5, {8'h00, 8'h00, 8'h00, 8'h80, 8'h01}},
      '{16'd100,   1'b0, 2'd2, 2'd2, 3, {8'h00, 8'h00, 8'h81, 16'h0}},
      '{16'd999,   1'b1, 2'd3, 2'd3, 4, {8'h09, 8'h09, 8'h09, 8'h80, 8'h00}},
      '{16'd1000,  1'b0, 2'd3, 2'd0, 4, {8'h00, 8'h00, 8'h00, 8'h81, 8'h00}},
      // checked against the predictor
      '{16'd12345, 1'b1, 2'd2, 2'd1, 0, '0},
      '{16'h5555,  1'b0, 2'd1, 2'd2, 0, '0},
      '{16'hAAAA,  1'b1, 2'd2, 2'd1, 0, '0},
      '{16'd32768, 1'b0, 2'd3, 2'd3, 0, '0},
      '{16'd255,   1'b1, 2'd0, 2'd0, 0, '0}
   };

   // chance in a hundred that the sender idles a cycle, one entry per phase
   int sender_idle_pct [3] = '{0, 59, 14};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [15:0] req_value = '0;
   logic        req_half = 1'b0;
   logic [1:0]  req_point_position = '0;
   logic [1:0]  req_chip_select = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [1:0]  rsp_target_chip;
   logic [3:0]  rsp_register_address;
   logic [7:0]  rsp_write_data;
   logic        rsp_last_write;

   // known digits travel beside the request so the monitor sees them at accept
   int              row_n_digits = 0;
   logic [0:4][7:0] row_digits = '0;

   digit_write_type pending_writes [$];
   int error_count = 0;
   int quiet_cycles = 0;

   seven_segment_number_formatter dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_value            (req_value),
      .req_half             (req_half),
      .req_point_position   (req_point_position),
      .req_chip_select      (req_chip_select),
      .rsp_strobe           (rsp_strobe),
      .rsp_target_chip      (rsp_target_chip),
      .rsp_register_address (rsp_register_address),
      .rsp_write_data       (rsp_write_data),
      .rsp_last_write       (rsp_last_write)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // queues the register writes for one number: blanks, then its digits
   function automatic void predict_digit_writes(input logic [15:0] value,
                                                input logic half,
                                                input logic [1:0] point,
                                                input logic [1:0] chip,
                                                input int n_digits,
                                                input logic [0:4][7:0] digits);
      logic [3:0]  top_addr;
      int unsigned rest;
      int unsigned pos;
      logic [7:0]  code;
      top_addr = half ? HALF_HIGH_TOP : HALF_LOW_TOP;
      // blank the half, highest address first
      for (pos = 0; pos < DIGITS_PER_HALF; pos++)
         pending_writes.push_back('{chip, top_addr - 4'(pos), BLANK_CODE, 1'b0});
      if (n_digits != 0) begin
         for (pos = 0; pos < n_digits; pos++)
            pending_writes.push_back('{chip, top_addr - 4'(pos), digits[pos], 1'b0});
      end else if (value == 16'd0) begin
         // zero shows a bare 0 with no point
         pending_writes.push_back('{chip, top_addr, 8'h00, 1'b0});
      end else begin
         rest = value;
         pos = 0;
         while (rest != 0) begin
            code = 8'(rest % 10);
            if (point != 2'd0 && pos == point)
               code = code | POINT_BIT;
            pending_writes.push_back('{chip, top_addr - 4'(pos), code, 1'b0});
            rest = rest / 10;
            pos++;
         end
         // pad with zeros up to the digit that carries the point
         if (point != 2'd0) begin
            while (pos <= point) begin
               code = (pos == point) ? POINT_BIT : 8'h00;
               pending_writes.push_back('{chip, top_addr - 4'(pos), code, 1'b0});
               pos++;
            end
         end
      end
      pending_writes[pending_writes.size() - 1].last = 1'b1;
   endfunction

   // checks writes first, then records the item accepted at this edge;
   // one process owns the queue so edge ordering cannot matter
   always @(posedge clock) begin
      digit_write_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (pending_writes.size() == 0) begin
               report_mismatch($sformatf("unexpected write chip %0d addr %0d data %h",
                                         rsp_target_chip, rsp_register_address,
                                         rsp_write_data));
            end else begin
               want = pending_writes.pop_front();
               if (rsp_target_chip !== want.chip)
                  report_mismatch($sformatf("target_chip got %0d want %0d",
                                            rsp_target_chip, want.chip));
               if (rsp_register_address !== want.addr)
                  report_mismatch($sformatf("register_address got %0d want %0d",
                                            rsp_register_address, want.addr));
               if (rsp_write_data !== want.data)
                  report_mismatch($sformatf("write_data got %h want %h",
                                            rsp_write_data, want.data));
               if (rsp_last_write !== want.last)
                  report_mismatch($sformatf("last_write got %b want %b",
                                            rsp_last_write, want.last));
            end
         end
         if (start && busy === 1'b0)
            predict_digit_writes(req_value, req_half, req_point_position,
                                 req_chip_select, row_n_digits, row_digits);
      end
   end

   // hang detection: any accepted item or write restarts the count
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[seven_segment_number_formatter] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // presents one item and returns at the edge that accepts it
   task automatic send_number(input logic [15:0] value, input logic half,
                              input logic [1:0] point, input logic [1:0] chip,
                              input int n_digits, input logic [0:4][7:0] digits);
      req_value <= value;
      req_half <= half;
      req_point_position <= point;
      req_chip_select <= chip;
      row_n_digits <= n_digits;
      row_digits <= digits;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // drops start for the given edges, optionally until every write is in
   task automatic pause_sender(input int cycles, input bit drain);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
      while (drain && pending_writes.size() != 0) @(posedge clock);
   endtask

   initial begin
      int          gap;
      int          phase;
      logic [15:0] value;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table, back to back
      foreach (directed_rows[i])
         send_number(directed_rows[i].value, directed_rows[i].half,
                     directed_rows[i].point, directed_rows[i].chip,
                     directed_rows[i].n_digits, directed_rows[i].digits);
      pause_sender(1, 1'b1);

      // random numbers, spread over every digit count
      for (phase = 0; phase < 3; phase++) begin
         repeat (ITEMS_PER_PHASE) begin
            gap = 0;
            while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct[phase])
               gap++;
            if (gap > 0)
               pause_sender(gap, 1'b0);
            case ($urandom_range(6))
               0: value = 16'd0;
               1: value = 16'($urandom_range(9, 1));
               2: value = 16'($urandom_range(99, 10));
               3: value = 16'($urandom_range(999, 100));
               4: value = 16'($urandom_range(9999, 1000));
               5: value = 16'($urandom_range(65535, 10000));
               default: value = 16'($urandom);
            endcase
            send_number(value, 1'($urandom), 2'($urandom), 2'($urandom), 0, '0);
         end
         // let the block drain between phases
         pause_sender(1, 1'b1);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_writes.size() == 0)
         $display("[seven_segment_number_formatter] OK");
      else
         $display("[seven_segment_number_formatter] ERROR");
      $finish;
   end

endmodule
